[design/fnvh_pkg.sv]
`default_nettype none
package fnvh_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned PIXEL_W = 32;

  // FNV-1a 64-bit constants; the prime is 2^40 + 2^8 + 0xb3
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [7:0]        PRIME_LO  = 8'hb3;
  localparam int unsigned       PRIME_SH_HI = 40;
  localparam int unsigned       PRIME_SH_MID = 8;

  localparam logic [HASH_W-1:0] BYTES_PER_PIXEL = 64'd3;
  localparam logic [HASH_W-1:0] COUNT_MAX       = {HASH_W{1'b1}};

  // byte round within one pixel
  typedef logic [1:0] round_t;
  localparam round_t ROUND_RED   = 2'd0;
  localparam round_t ROUND_GREEN = 2'd1;
  localparam round_t ROUND_BLUE  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FOLD
  } state_t;

  // sequencer controls
  typedef struct packed {
    logic advance;
    logic final_round;
    logic emit;
  } ctrl_t;

endpackage
`default_nettype wire

[design/fnv1a64_rgb_frame_hash.sv]
// A pixel accepted into the pixel register is folded in three dependent rounds,
// one byte (red, green, blue) per cycle through a single xor-multiply unit
// unless the blue round holds. A new pixel is taken when idle or as blue completes.
// On a last pixel the hash and byte count land in the output register after the
// blue round; that blue round holds while an earlier result is still untaken.
// Reset (rst, synchronous): hash to the FNV offset basis, count to zero, no result.
`default_nettype none
module fnv1a64_rgb_frame_hash
  import fnvh_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // pixel[31:0]
  input  wire logic         s_axis_tlast,   // last
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata    // frame_hash[63:0], byte_count[127:64]
);

  state_t              state, state_next;
  round_t              round;
  logic [23:0]         pixel;
  logic                last_q;
  logic [HASH_W-1:0]   hash;
  logic [HASH_W-1:0]   count;
  ctrl_t               ctrl;
  logic                in_beat;

  logic [7:0]          fold_byte;
  logic [HASH_W-1:0]   fold_x;
  logic [HASH_W-1:0]   fold_mul;
  logic [HASH_W-1:0]   fold_out;
  logic [HASH_W-1:0]   count_inc;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // select the byte for this round
  always_comb begin
    case (round)
      ROUND_RED:   fold_byte = pixel[23:16];
      ROUND_GREEN: fold_byte = pixel[15:8];
      ROUND_BLUE:  fold_byte = pixel[7:0];
      default:     fold_byte = pixel[7:0];
    endcase
  end

  // shared fold unit: xor the byte, multiply by the prime as two shifts plus a multiply by its low byte
  assign fold_x   = hash ^ {{(HASH_W-8){1'b0}}, fold_byte};
  assign fold_mul = fold_x * {{(HASH_W-8){1'b0}}, PRIME_LO};
  assign fold_out = (fold_x << PRIME_SH_HI) + (fold_x << PRIME_SH_MID) + fold_mul;

  // saturating byte count
  assign count_inc = (count > COUNT_MAX - BYTES_PER_PIXEL) ? COUNT_MAX
                   : count + BYTES_PER_PIXEL;

  // sequencer outputs
  always_comb begin
    ctrl.final_round = (state == ST_FOLD) && (round == ROUND_BLUE);
    ctrl.advance     = (state == ST_FOLD) &&
                       !(ctrl.final_round && last_q && m_axis_tvalid && !m_axis_tready);
    ctrl.emit        = ctrl.advance && ctrl.final_round && last_q;
    s_axis_tready    = (state == ST_IDLE) || (ctrl.advance && ctrl.final_round);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (ctrl.advance && ctrl.final_round && !in_beat) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      round         <= ROUND_RED;
      hash          <= FNV_BASIS;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // advance the round counter
      if (in_beat) begin
        round <= ROUND_RED;
      end else if (ctrl.advance) begin
        round <= round + round_t'(1);
      end
      // fold one byte; restart the frame after a last pixel
      if (ctrl.emit) begin
        hash  <= FNV_BASIS;
        count <= '0;
      end else if (ctrl.advance) begin
        hash <= fold_out;
        if (ctrl.final_round) count <= count_inc;
      end
      // output valid
      if (ctrl.emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      pixel  <= s_axis_tdata[23:0];
      last_q <= s_axis_tlast;
    end
    if (ctrl.emit) begin
      m_axis_tdata <= {count_inc, fold_out};
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_red: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_FOLD) && (round == ROUND_RED))
    else $error("accepted pixel did not start at the red round");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> m_axis_tvalid)
    else $error("result of a last pixel not presented");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> (m_axis_tdata[127:64] != '0))
    else $error("emitted byte count is zero");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> (round == ROUND_RED || round == ROUND_GREEN ||
                            round == ROUND_BLUE))
    else $error("round counter out of range");
`endif

endmodule
`default_nettype wire
